@@ hdl/swmc_pkg.sv @@
// Package for the sliding-window median cost block.
// Holds the fixed widths, the controller state type and the cell command struct.
// It depends on nothing else.
`default_nettype none

package swmc_pkg;

  // Fixed field widths.
  localparam int COST_W   = 38;
  localparam int CFG_W    = 7;

  // Window size after reset, before saturation to the built maximum.
  localparam int WIN_RESET = 8;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REMOVE,
    ST_INSERT,
    ST_LOAD,
    ST_SUM,
    ST_DONE
  } state_t;

  // Commands broadcast from the controller to the cell chain and datapath.
  typedef struct packed {
    logic accept;    // input transaction taken this cycle
    logic remove;    // drop the oldest sample from the sorted chain
    logic insert;    // place the new sample into the sorted chain
    logic load_dev;  // capture per-cell deviation from the median
    logic sum;       // shift deviations toward cell 0 and accumulate
    logic out_load;  // move the finished cost into the output register
  } cell_cmd_t;

endpackage

`default_nettype wire

@@ hdl/swmc_ifs.sv @@
// Valid/ready channel interfaces for the sliding-window median cost block.
// Depends on swmc_pkg for the cost width.
`default_nettype none

// Sample input channel.
interface swmc_in_if #(
  parameter int SAMPLE_BITS = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          last_sample;

  modport source (output valid, output sample, output last_sample, input ready);
  modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

// Cost result channel.
interface swmc_out_if;
  logic                       valid;
  logic                       ready;
  logic [swmc_pkg::COST_W-1:0] cost;

  modport source (output valid, output cost, input ready);
  modport sink   (input valid, input cost, output ready);
endinterface

`default_nettype wire

@@ hdl/swmc_cell.sv @@
// One cell of the sorted window chain: a sample value, its age and a deviation.
// Depends on swmc_pkg for the command struct.
`default_nettype none

module swmc_cell #(
  parameter int SAMPLE_BITS = 32,
  parameter int CNT_W       = 7,
  parameter int IDX_W       = 6,
  parameter int CELL_IDX    = 0
) (
  input  wire                           clk,
  input  wire swmc_pkg::cell_cmd_t      cmd,
  input  wire logic [SAMPLE_BITS-1:0]   x,
  input  wire logic [CNT_W-1:0]         win,
  input  wire logic [CNT_W-1:0]         fill,
  input  wire logic [IDX_W-1:0]         evict_idx,
  input  wire logic [SAMPLE_BITS-1:0]   median,
  input  wire logic [SAMPLE_BITS-1:0]   left_value,
  input  wire logic [IDX_W-1:0]         left_age,
  input  wire logic                     left_gt,
  input  wire logic [SAMPLE_BITS-1:0]   right_value,
  input  wire logic [IDX_W-1:0]         right_age,
  input  wire logic [SAMPLE_BITS-1:0]   right_dev,
  output logic      [SAMPLE_BITS-1:0]   value,
  output logic      [IDX_W-1:0]         age,
  output logic                          gt,
  output logic                          evict,
  output logic      [SAMPLE_BITS-1:0]   dev
);

  localparam logic [CNT_W-1:0] POS = CNT_W'(CELL_IDX);

  logic [SAMPLE_BITS-1:0] value_r, value_nxt;
  logic [IDX_W-1:0]       age_r, age_nxt;
  logic [SAMPLE_BITS-1:0] dev_r, dev_nxt;
  logic                   occupied;
  logic                   at_fill;
  logic                   shift_up;
  logic signed [SAMPLE_BITS:0] diff;
  logic [SAMPLE_BITS:0]   diff_abs;

  // Occupancy and neighbor-facing flags.
  assign occupied = POS < fill;
  assign at_fill  = POS == fill;
  assign gt       = occupied && ($signed(value_r) > $signed(x));
  assign evict    = occupied && (age_r == IDX_W'(win - CNT_W'(1)));
  assign shift_up = POS >= CNT_W'(evict_idx);

  // Deviation from the median, taken one bit wider and then made positive.
  assign diff     = $signed({value_r[SAMPLE_BITS-1], value_r})
                  - $signed({median[SAMPLE_BITS-1], median});
  assign diff_abs = diff[SAMPLE_BITS] ? (SAMPLE_BITS+1)'(-diff) : diff;

  // Next cell contents for each command.
  always_comb begin
    value_nxt = value_r;
    age_nxt   = age_r;
    dev_nxt   = dev_r;
    if (cmd.remove && shift_up) begin
      value_nxt = right_value;
      age_nxt   = right_age;
    end
    if (cmd.insert) begin
      if (left_gt) begin
        value_nxt = left_value;
        age_nxt   = left_age + IDX_W'(1);
      end else if (gt || at_fill) begin
        value_nxt = x;
        age_nxt   = '0;
      end else begin
        age_nxt   = age_r + IDX_W'(1);
      end
    end
    if (cmd.load_dev) begin
      dev_nxt = (POS < win) ? diff_abs[SAMPLE_BITS-1:0] : '0;
    end
    if (cmd.sum) begin
      dev_nxt = right_dev;
    end
  end

  // Payload registers; they need no reset.
  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    age_r   <= age_nxt;
    dev_r   <= dev_nxt;
  end

  assign value = value_r;
  assign age   = age_r;
  assign dev   = dev_r;

endmodule

`default_nettype wire

@@ hdl/swmc_ctrl.sv @@
// Sequencer for the sliding-window median cost block: window size, fill count
// and the per-item command sequence. Depends on swmc_pkg.
`default_nettype none

module swmc_ctrl #(
  parameter int WINDOW_MAX = 64,
  parameter int CNT_W      = 7
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire logic                         in_valid,
  input  wire logic                         in_last,
  input  wire logic                         cfg_we,
  input  wire logic [swmc_pkg::CFG_W-1:0]   cfg_wdata,
  input  wire logic                         out_free,
  output logic                              in_ready,
  output logic      [CNT_W-1:0]             win,
  output logic      [CNT_W-1:0]             fill,
  output swmc_pkg::cell_cmd_t               cmd
);

  localparam int WIN_RST = (swmc_pkg::WIN_RESET > WINDOW_MAX) ? WINDOW_MAX
                                                               : swmc_pkg::WIN_RESET;

  swmc_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0] win_r, win_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             last_r, last_nxt;
  logic             produce;

  // The insert completes a full window.
  assign produce = (fill_r + CNT_W'(1)) == win_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      swmc_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (fill_r == win_r) ? swmc_pkg::ST_REMOVE : swmc_pkg::ST_INSERT;
        end
      end
      swmc_pkg::ST_REMOVE: state_nxt = swmc_pkg::ST_INSERT;
      swmc_pkg::ST_INSERT: state_nxt = produce ? swmc_pkg::ST_LOAD : swmc_pkg::ST_IDLE;
      swmc_pkg::ST_LOAD:   state_nxt = swmc_pkg::ST_SUM;
      swmc_pkg::ST_SUM: begin
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = swmc_pkg::ST_DONE;
        end
      end
      swmc_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = swmc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = swmc_pkg::ST_IDLE;
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      swmc_pkg::ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      swmc_pkg::ST_REMOVE: cmd.remove   = 1'b1;
      swmc_pkg::ST_INSERT: cmd.insert   = 1'b1;
      swmc_pkg::ST_LOAD:   cmd.load_dev = 1'b1;
      swmc_pkg::ST_SUM:    cmd.sum      = 1'b1;
      swmc_pkg::ST_DONE:   cmd.out_load = out_free;
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

  // Window size, fill count, sum counter and the captured last flag.
  always_comb begin
    win_nxt  = win_r;
    fill_nxt = fill_r;
    cnt_nxt  = cnt_r;
    last_nxt = last_r;
    if (cmd.accept) begin
      last_nxt = in_last;
    end
    if (cmd.remove) begin
      fill_nxt = fill_r - CNT_W'(1);
    end
    if (cmd.insert) begin
      fill_nxt = last_r ? '0 : fill_r + CNT_W'(1);
    end
    if (cmd.load_dev) begin
      cnt_nxt = win_r;
    end
    if (cmd.sum) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
    if (cfg_we) begin
      fill_nxt = '0;
      if (cfg_wdata == '0) begin
        win_nxt = CNT_W'(1);
      end else if (int'(cfg_wdata) > WINDOW_MAX) begin
        win_nxt = CNT_W'(WINDOW_MAX);
      end else begin
        win_nxt = CNT_W'(cfg_wdata);
      end
    end
  end

  // Control registers with synchronous reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= swmc_pkg::ST_IDLE;
      win_r   <= CNT_W'(WIN_RST);
      fill_r  <= '0;
      cnt_r   <= '0;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      win_r   <= win_nxt;
      fill_r  <= fill_nxt;
      cnt_r   <= cnt_nxt;
      last_r  <= last_nxt;
    end
  end

  assign win  = win_r;
  assign fill = fill_r;

endmodule

`default_nettype wire

@@ hdl/sliding_window_median_cost.sv @@
// Top level of the sliding-window median cost block: cell chain, median select,
// cost accumulator and output register. Depends on swmc_pkg, swmc_ifs,
// swmc_cell and swmc_ctrl.
//
//   Channel   Dir  Handshake      Payload
//   in_chan   in   valid/ready    sample (signed, SAMPLE_BITS), last_sample
//   out_chan  out  valid/ready    cost (unsigned, 38 bits)
//   cfg_*     in   cfg_we         cfg_window_size (7 bits)
//
// An item that leaves the window short of full passes through accept and insert.
// An item that first fills the window goes through accept, insert, deviation load,
// the shift of the deviations into the accumulator, and output hand-off.
// At a full window a removal of the oldest sample comes before the insert.
// The hand-off stalls while an unaccepted result holds the output register.
// Synchronous reset empties the window and sets the size to min(8, WINDOW_MAX).
`default_nettype none

module sliding_window_median_cost #(
  parameter int WINDOW_MAX  = 64,
  parameter int SAMPLE_BITS = 32
) (
  input  wire                               clk,
  input  wire                               rst_n,
  swmc_in_if.sink                           in_chan,
  swmc_out_if.source                        out_chan,
  input  wire logic                         cfg_we,
  input  wire logic [swmc_pkg::CFG_W-1:0]   cfg_window_size
);

  localparam int CNT_W = $clog2(WINDOW_MAX + 1);
  localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int ACC_W = SAMPLE_BITS + CNT_W;
  localparam int EXT_W = (ACC_W > swmc_pkg::COST_W) ? ACC_W : swmc_pkg::COST_W;
  localparam logic [EXT_W-1:0] COST_MAX = EXT_W'({swmc_pkg::COST_W{1'b1}});

  swmc_pkg::cell_cmd_t cmd;
  logic [CNT_W-1:0]       win;
  logic [CNT_W-1:0]       fill;
  logic                   out_free;
  logic [SAMPLE_BITS-1:0] x_r, x_nxt;
  logic [SAMPLE_BITS-1:0] value_w [WINDOW_MAX];
  logic [IDX_W-1:0]       age_w   [WINDOW_MAX];
  logic [SAMPLE_BITS-1:0] dev_w   [WINDOW_MAX];
  logic [WINDOW_MAX-1:0]  gt_vec;
  logic [WINDOW_MAX-1:0]  evict_vec;
  logic [IDX_W-1:0]       evict_idx;
  logic [IDX_W-1:0]       mid_idx;
  logic [SAMPLE_BITS-1:0] median;
  logic [ACC_W-1:0]       acc_r, acc_nxt;
  logic [EXT_W-1:0]       acc_ext;
  logic [swmc_pkg::COST_W-1:0] cost_r, cost_nxt;
  logic                   out_valid_r, out_valid_nxt;

  // Sequencer.
  swmc_ctrl #(
    .WINDOW_MAX (WINDOW_MAX),
    .CNT_W      (CNT_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_last   (in_chan.last_sample),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_window_size),
    .out_free  (out_free),
    .in_ready  (in_chan.ready),
    .win       (win),
    .fill      (fill),
    .cmd       (cmd)
  );

  // Capture the sample of each accepted transaction.
  assign x_nxt = cmd.accept ? in_chan.sample : x_r;

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
  end

  // Encode the cell that holds the oldest sample.
  always_comb begin
    evict_idx = '0;
    for (int i = 0; i < WINDOW_MAX; i++) begin
      if (evict_vec[i]) begin
        evict_idx = evict_idx | IDX_W'(i);
      end
    end
  end

  // Lower median of the full window.
  assign mid_idx = IDX_W'((win - CNT_W'(1)) >> 1);
  assign median  = value_w[mid_idx];

  // Chain of sorted cells; cell 0 holds the smallest sample.
  for (genvar g = 0; g < WINDOW_MAX; g++) begin : g_cell
    logic [SAMPLE_BITS-1:0] left_value;
    logic [IDX_W-1:0]       left_age;
    logic                   left_gt;
    logic [SAMPLE_BITS-1:0] right_value;
    logic [IDX_W-1:0]       right_age;
    logic [SAMPLE_BITS-1:0] right_dev;

    if (g == 0) begin : g_first
      assign left_value = '0;
      assign left_age   = '0;
      assign left_gt    = 1'b0;
    end else begin : g_mid_left
      assign left_value = value_w[g-1];
      assign left_age   = age_w[g-1];
      assign left_gt    = gt_vec[g-1];
    end

    if (g == WINDOW_MAX - 1) begin : g_last
      assign right_value = value_w[g];
      assign right_age   = age_w[g];
      assign right_dev   = '0;
    end else begin : g_mid_right
      assign right_value = value_w[g+1];
      assign right_age   = age_w[g+1];
      assign right_dev   = dev_w[g+1];
    end

    swmc_cell #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .CNT_W       (CNT_W),
      .IDX_W       (IDX_W),
      .CELL_IDX    (g)
    ) u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .x           (x_r),
      .win         (win),
      .fill        (fill),
      .evict_idx   (evict_idx),
      .median      (median),
      .left_value  (left_value),
      .left_age    (left_age),
      .left_gt     (left_gt),
      .right_value (right_value),
      .right_age   (right_age),
      .right_dev   (right_dev),
      .value       (value_w[g]),
      .age         (age_w[g]),
      .gt          (gt_vec[g]),
      .evict       (evict_vec[g]),
      .dev         (dev_w[g])
    );
  end

  // Accumulate the deviations as they leave cell 0.
  always_comb begin
    acc_nxt = acc_r;
    if (cmd.load_dev) begin
      acc_nxt = '0;
    end else if (cmd.sum) begin
      acc_nxt = acc_r + ACC_W'(dev_w[0]);
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  // Widen the sum for saturation to the cost width.
  assign acc_ext = EXT_W'(acc_r);

  // Output register.
  assign out_free = !out_valid_r || out_chan.ready;

  always_comb begin
    cost_nxt      = cost_r;
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      cost_nxt      = (acc_ext > COST_MAX) ? '1 : acc_ext[swmc_pkg::COST_W-1:0];
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cost_r <= cost_nxt;
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.cost  = cost_r;

  // The window never holds more samples than its configured size.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill <= win)
    else $error("fill count above window size");

  // Exactly one cell carries the oldest age when a sample is evicted.
  a_one_evict: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.remove |-> $onehot(evict_vec))
    else $error("eviction does not hit exactly one cell");

  // An accepted transaction goes straight into the cell chain.
  a_accept_next: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> (cmd.remove || cmd.insert))
    else $error("accepted transaction not processed");

  // A result appears only after a completed summation.
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.out_load))
    else $error("result without a finished sum");

endmodule

`default_nettype wire

@@ dv/tb_sliding_window_median_cost.sv @@
// Self-checking testbench for sliding_window_median_cost: it drives sample transactions,
// predicts the median cost of each full window and checks every result transaction.
// Depends on swmc_pkg, swmc_ifs and the block's RTL.
`default_nettype none

module tb_sliding_window_median_cost;

  localparam int WINDOW_MAX  = 64;
  localparam int SAMPLE_BITS = 32;
  localparam int COST_W      = swmc_pkg::COST_W;
  localparam int CFG_W       = swmc_pkg::CFG_W;
  localparam longint COST_SAT = (longint'(1) << COST_W) - 1;
  localparam int SETTLE_CYCLES = 10;
  localparam int RANDOM_ITEMS  = 800;

  // Sample modes for the random phases.
  localparam int MODE_MIXED    = 0;
  localparam int MODE_EXTREMES = 1;
  localparam int MODE_CLUSTER  = 2;

  logic clk;
  logic rst_n;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_window_size;

  swmc_in_if #(.SAMPLE_BITS(SAMPLE_BITS)) in_if ();
  swmc_out_if                              out_if ();

  sliding_window_median_cost #(
    .WINDOW_MAX (WINDOW_MAX),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_chan        (in_if),
    .out_chan       (out_if),
    .cfg_we         (cfg_we),
    .cfg_window_size(cfg_window_size)
  );

  // Predictor state: configured window length and the samples in arrival order.
  int                             win_len;
  logic signed [SAMPLE_BITS-1:0]  window_q[$];
  logic [COST_W-1:0]              cost_q[$];
  logic [COST_W-1:0]              want_cost;

  int  error_count;
  int  items_sent;
  bit  calm_in;
  bit  calm_out;
  int  sample_mode;

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog for a hung run.
  initial begin
    #5000000;
    $display("Simulation FAILED");
    $finish;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Sum of absolute deviations from the lower median of the current window.
  function automatic logic [COST_W-1:0] window_cost();
    longint ranked[WINDOW_MAX];
    longint v;
    longint median;
    longint total;
    int     n;
    int     j;
    n = window_q.size();
    for (int i = 0; i < n; i++) begin
      v = longint'(window_q[i]);
      j = i;
      while (j > 0 && ranked[j-1] > v) begin
        ranked[j] = ranked[j-1];
        j--;
      end
      ranked[j] = v;
    end
    median = ranked[(n - 1) / 2];
    total = 0;
    for (int i = 0; i < n; i++) begin
      total += (ranked[i] > median) ? ranked[i] - median : median - ranked[i];
    end
    if (total > COST_SAT) total = COST_SAT;
    return total[COST_W-1:0];
  endfunction

  // Advance the window by one accepted sample and queue the cost it yields.
  function automatic void take_sample(logic signed [SAMPLE_BITS-1:0] s, logic last);
    if (window_q.size() >= win_len) void'(window_q.pop_front());
    window_q.push_back(s);
    if (window_q.size() == win_len) cost_q.push_back(window_cost());
    if (last) window_q.delete();
  endfunction

  // A size write clamps to 1..WINDOW_MAX and empties the window.
  function automatic void set_window_len(logic [CFG_W-1:0] v);
    if (v == 0) win_len = 1;
    else if (v > WINDOW_MAX) win_len = WINDOW_MAX;
    else win_len = int'(v);
    window_q.delete();
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
    int r = $urandom_range(0, 99);
    if (sample_mode == MODE_EXTREMES) begin
      return r[0] ? 32'sh7fffffff : 32'sh80000000;
    end
    if (sample_mode == MODE_CLUSTER) begin
      return $signed($urandom_range(0, 16)) - 8;
    end
    if (r < 50) return $urandom;
    if (r < 70) return $signed($urandom_range(0, 20)) - 10;
    if (r < 80) return 32'sh7fffffff - $urandom_range(0, 3);
    if (r < 90) return 32'sh80000000 + $urandom_range(0, 3);
    return $signed($urandom_range(0, 2000)) - 1000;
  endfunction

  // Result receiver: random stalls, with stretches of none.
  initial begin
    int stall_left;
    stall_left = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_if.ready = 1'b0;
        stall_left--;
      end else begin
        out_if.ready = 1'b1;
        if (!calm_out && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  // Monitor: check each result transaction, then predict from each sample transaction.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        if (cost_q.size() == 0) begin
          $error("unexpected result: cost %0d", out_if.cost);
          error_count++;
        end else begin
          want_cost = cost_q.pop_front();
          if (out_if.cost !== want_cost) begin
            $error("cost mismatch: expected %0d, actual %0d", want_cost, out_if.cost);
            error_count++;
          end
        end
      end
      if (in_if.valid && in_if.ready) take_sample(in_if.sample, in_if.last_sample);
    end
  end

  // Send one sample transaction; called and returning at a falling edge.
  task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] s, input logic last);
    int gap;
    in_if.valid       = 1'b1;
    in_if.sample      = s;
    in_if.last_sample = last;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
    gap = calm_in ? 0 : pick_gap();
    if (gap > 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Hold off the sender until every expected cost has come back.
  task automatic drain_results();
    in_if.valid = 1'b0;
    while (cost_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_window_size(input logic [CFG_W-1:0] v);
    drain_results();
    cfg_we          = 1'b1;
    cfg_window_size = v;
    set_window_len(v);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Default size of 8 after reset, with extreme and ordinary values.
  task automatic test_default_window();
    send_sample(32'sh80000000, 1'b0);
    send_sample(32'sh7fffffff, 1'b0);
    send_sample(32'sd0, 1'b0);
    send_sample(-32'sd1, 1'b0);
    send_sample(32'sd1, 1'b0);
    send_sample(32'sd5, 1'b0);
    send_sample(32'sd5, 1'b0);
    send_sample(-32'sd100, 1'b0);
    send_sample(32'sh7fffffff, 1'b1);
    drain_results();
  endtask

  // Size zero acts as a window of one: every sample costs nothing.
  task automatic test_size_zero();
    write_window_size('0);
    send_sample(32'sh7fffffff, 1'b0);
    send_sample(32'sh80000000, 1'b1);
    drain_results();
  endtask

  // Widest possible spread between two samples.
  task automatic test_extreme_spread();
    write_window_size(2);
    send_sample(32'sh80000000, 1'b0);
    send_sample(32'sh7fffffff, 1'b0);
    send_sample(32'sh80000000, 1'b1);
    drain_results();
  endtask

  // A last flag before the window fills gives no result but still clears it.
  task automatic test_last_before_full();
    write_window_size(3);
    send_sample(32'sd10, 1'b0);
    send_sample(32'sd20, 1'b1);
    send_sample(32'sd7, 1'b0);
    send_sample(-32'sd7, 1'b0);
    send_sample(32'sd3, 1'b1);
    drain_results();
  endtask

  // An oversize write saturates, and any size write empties a partial window.
  task automatic test_resize_mid_stream();
    write_window_size(7'h7f);
    send_sample(32'sd1000, 1'b0);
    send_sample(-32'sd1000, 1'b0);
    write_window_size(2);
    send_sample(32'sd4, 1'b0);
    send_sample(32'sd9, 1'b0);
    drain_results();
  endtask

  // Random phases: new size, then sequences mostly closed by a last flag, with some noise.
  task automatic test_random_stream();
    int stop_at;
    int seq_len;
    int n_seq;
    int r;
    logic [CFG_W-1:0] size_val;
    stop_at = items_sent + RANDOM_ITEMS;
    while (items_sent < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 60)      size_val = CFG_W'($urandom_range(1, 12));
      else if (r < 75) size_val = CFG_W'($urandom_range(13, 63));
      else if (r < 85) size_val = CFG_W'(WINDOW_MAX);
      else if (r < 95) size_val = CFG_W'($urandom_range(65, 127));
      else             size_val = '0;
      write_window_size(size_val);
      r = $urandom_range(0, 9);
      sample_mode = (r < 6) ? MODE_MIXED : (r < 8) ? MODE_EXTREMES : MODE_CLUSTER;
      n_seq = $urandom_range(2, 5);
      for (int s = 0; s < n_seq && items_sent < stop_at; s++) begin
        calm_in  = ($urandom_range(0, 4) == 0);
        calm_out = ($urandom_range(0, 4) == 0);
        seq_len = $urandom_range(1, 3 * win_len + 2);
        for (int i = 0; i < seq_len && items_sent < stop_at; i++) begin
          if (i == seq_len - 1)
            send_sample(rand_sample(), $urandom_range(0, 99) < 85);
          else
            send_sample(rand_sample(), $urandom_range(0, 99) < 3);
        end
      end
    end
    calm_in  = 1'b0;
    calm_out = 1'b0;
  endtask

  // Test sequence.
  initial begin
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_window_size   = '0;
    in_if.valid       = 1'b0;
    in_if.sample      = '0;
    in_if.last_sample = 1'b0;
    error_count       = 0;
    items_sent        = 0;
    calm_in           = 1'b0;
    calm_out          = 1'b0;
    sample_mode       = MODE_MIXED;
    win_len           = swmc_pkg::WIN_RESET;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_default_window();
    test_size_zero();
    test_extreme_spread();
    test_last_before_full();
    test_resize_mid_stream();
    test_random_stream();

    drain_results();
    repeat (WINDOW_MAX + SETTLE_CYCLES) @(negedge clk);
    if (cost_q.size() != 0) begin
      $error("%0d expected cost results never arrived", cost_q.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ filelist.f @@
hdl/swmc_pkg.sv
hdl/swmc_ifs.sv
hdl/swmc_cell.sv
hdl/swmc_ctrl.sv
hdl/sliding_window_median_cost.sv
dv/tb_sliding_window_median_cost.sv
